// ----- rtl/hpq_pkg.sv -----
// hpq_pkg: shared types and constants of the max-heap priority queue
// depends on nothing; imported by hpq_ctrl, hpq_dp and max_heap_priority_queue
package hpq_pkg;

	localparam int VAL_W = 32;
	localparam int CAP_W = 11;
	localparam int POS_W = 11;
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

	// request kinds
	localparam logic ACT_INSERT  = 1'b0;
	localparam logic ACT_EXTRACT = 1'b1;

	// result status codes
	localparam logic ST_DONE   = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_EX_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} ctrl_state_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INS_START,
		OP_EXT_START,
		OP_REJECT,
		OP_PLACE,
		OP_UP_READ,
		OP_UP_MOVE,
		OP_EX_LOAD,
		OP_DN_READ,
		OP_DN_MOVE,
		OP_OUT
	} dp_op_t;

	// status flags from datapath to controller
	typedef struct packed {
		logic full;      // count at or above the effective bound
		logic empty;     // count is zero
		logic root;      // moving entry sits at the root
		logic up_gt;     // moving entry strictly greater than its parent
		logic last;      // heap emptied by the current extract
		logic leaf;      // moving entry has no children
		logic dn_gt;     // larger child strictly greater than moving entry
		logic out_free;  // result register can take a new result
	} dp_stat_t;

endpackage

// ----- rtl/hpq_ctrl.sv -----
// hpq_ctrl: sequencing state machine of the heap priority queue
// depends on hpq_pkg; drives the datapath operation code in hpq_dp
module hpq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             action,
	input  hpq_pkg::dp_stat_t stat,
	output hpq_pkg::dp_op_t   op
);
	import hpq_pkg::*;

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and operation select
	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (action == ACT_INSERT) begin
						if (stat.full) begin
							op      = OP_REJECT;
							state_d = S_DONE;
						end else begin
							op      = OP_INS_START;
							state_d = S_UP_RD;
						end
					end else begin
						if (stat.empty) begin
							op      = OP_REJECT;
							state_d = S_DONE;
						end else begin
							op      = OP_EXT_START;
							state_d = S_EX_LOAD;
						end
					end
				end
			end
			S_UP_RD: begin
				if (stat.root) begin
					op      = OP_PLACE;
					state_d = S_DONE;
				end else begin
					op      = OP_UP_READ;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_gt) begin
					op      = OP_UP_MOVE;
					state_d = S_UP_RD;
				end else begin
					op      = OP_PLACE;
					state_d = S_DONE;
				end
			end
			S_EX_LOAD: begin
				op      = OP_EX_LOAD;
				state_d = stat.last ? S_DONE : S_DN_RD;
			end
			S_DN_RD: begin
				if (stat.leaf) begin
					op      = OP_PLACE;
					state_d = S_DONE;
				end else begin
					op      = OP_DN_READ;
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (stat.dn_gt) begin
					op      = OP_DN_MOVE;
					state_d = S_DN_RD;
				end else begin
					op      = OP_PLACE;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					op      = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/hpq_dp.sv -----
// hpq_dp: heap memory, index and value registers, result register
// depends on hpq_pkg; operated by hpq_ctrl through dp_op_t
module hpq_dp #(
	parameter int DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [hpq_pkg::CAP_W-1:0]    cfg_wdata,
	input  logic signed [hpq_pkg::VAL_W-1:0] value,
	input  hpq_pkg::dp_op_t              op,
	output hpq_pkg::dp_stat_t            stat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         status,
	output logic [hpq_pkg::POS_W-1:0]    position,
	output logic signed [hpq_pkg::VAL_W-1:0] max_value
);
	import hpq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int BW = (CW > CAP_W) ? CW : CAP_W;
	localparam int LW = AW + 2;
	localparam int PW = (AW + 1 > POS_W) ? AW + 1 : POS_W;

	logic signed [VAL_W-1:0] mem [DEPTH];

	logic [CAP_W-1:0]        cap_q;
	logic [CW-1:0]           count_q;
	logic [AW-1:0]           idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] max_q;
	logic                    pend_status_q;
	logic [POS_W-1:0]        pend_pos_q;
	logic                    out_valid_q;
	logic                    status_q;
	logic [POS_W-1:0]        position_q;
	logic signed [VAL_W-1:0] max_value_q;
	logic signed [VAL_W-1:0] rd0_q, rd1_q;

	logic [AW-1:0]           ra0, ra1, wa;
	logic                    we;
	logic signed [VAL_W-1:0] wd;
	logic [BW-1:0]           bound;
	logic [AW-1:0]           parent;
	logic [LW-1:0]           left_w, right_w, count_w;
	logic                    right_ok, pick_right;
	logic signed [VAL_W-1:0] child_val;
	logic [AW-1:0]           child_idx;
	logic [PW-1:0]           pos_w;

	// effective bound and index arithmetic
	always_comb begin
		bound      = (BW'(cap_q) < BW'(DEPTH)) ? BW'(cap_q) : BW'(DEPTH);
		parent     = (idx_q - AW'(1)) >> 1;
		left_w     = {1'b0, idx_q, 1'b1};
		right_w    = left_w + LW'(1);
		count_w    = LW'(count_q);
		right_ok   = right_w < count_w;
		pick_right = right_ok && (rd1_q > rd0_q);
		child_val  = pick_right ? rd1_q : rd0_q;
		child_idx  = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
		pos_w      = PW'(idx_q) + PW'(1);
	end

	// status flags
	always_comb begin
		stat.full     = BW'(count_q) >= bound;
		stat.empty    = count_q == '0;
		stat.root     = idx_q == '0;
		stat.up_gt    = val_q > rd0_q;
		stat.last     = count_q == '0;
		stat.leaf     = left_w >= count_w;
		stat.dn_gt    = child_val > val_q;
		stat.out_free = !out_valid_q || out_ready;
	end

	// memory port selection
	always_comb begin
		ra0 = parent;
		ra1 = AW'(count_q - CW'(1));
		we  = 1'b0;
		wa  = idx_q;
		wd  = val_q;
		case (op)
			OP_EXT_START: begin
				ra0 = '0;
			end
			OP_DN_READ: begin
				ra0 = left_w[AW-1:0];
				ra1 = right_w[AW-1:0];
			end
			OP_PLACE: begin
				we = 1'b1;
			end
			OP_UP_MOVE: begin
				we = 1'b1;
				wd = rd0_q;
			end
			OP_DN_MOVE: begin
				we = 1'b1;
				wd = child_val;
			end
			default: begin
			end
		endcase
	end

	// heap memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op == OP_INS_START) begin
			count_q <= count_q + CW'(1);
		end else if (op == OP_EXT_START) begin
			count_q <= count_q - CW'(1);
		end
	end

	// working registers and pending result
	always_ff @(posedge clk) begin
		case (op)
			OP_INS_START: begin
				val_q         <= value;
				idx_q         <= AW'(count_q);
				max_q         <= '0;
				pend_status_q <= ST_DONE;
			end
			OP_EXT_START: begin
				pend_status_q <= ST_DONE;
			end
			OP_REJECT: begin
				pend_status_q <= ST_REJECT;
				pend_pos_q    <= '0;
				max_q         <= '0;
			end
			OP_PLACE: begin
				pend_pos_q <= pos_w[POS_W-1:0];
			end
			OP_UP_MOVE: begin
				idx_q <= parent;
			end
			OP_EX_LOAD: begin
				max_q <= rd0_q;
				if (count_q == '0) begin
					pend_pos_q <= '0;
				end else begin
					val_q <= rd1_q;
					idx_q <= '0;
				end
			end
			OP_DN_MOVE: begin
				idx_q <= child_idx;
			end
			default: begin
			end
		endcase
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (op == OP_OUT) begin
			status_q    <= pend_status_q;
			position_q  <= pend_pos_q;
			max_value_q <= max_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;
	assign max_value = max_value_q;

endmodule

// ----- rtl/max_heap_priority_queue.sv -----
// max_heap_priority_queue: bounded binary max-heap priority queue, top level
// depends on hpq_pkg, hpq_ctrl and hpq_dp
//
// Usage:
//   Input channel in_valid/in_ready carries one request: action 0 inserts
//   value, action 1 extracts the maximum. Output channel out_valid/out_ready
//   returns status, position and max_value for every request.
//   cfg_we/cfg_wdata write the capacity register; the user must write it only
//   while the block is idle, as the block itself does not enforce this.
// Timing:
//   One request is worked at a time; each level of the sift is a read step,
//   then a compare and move step, on a memory with two registered reads.
//   An insert sifts up until the root or a parent that is not smaller; an
//   extract loads the root and the last entry and sifts down to a leaf or
//   until no child is greater, unless it empties the heap; a reject skips both.
// Reset: the heap is empty and capacity is 1024; the memory is not cleared.
// Stall: a finished result sits in the output register; the next request is
//   taken and worked while it waits, and is held back only when its own
//   result is ready before the previous one has been taken.
module max_heap_priority_queue #(
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hpq_pkg::CAP_W-1:0]        cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic signed [hpq_pkg::VAL_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             status,
	output logic [hpq_pkg::POS_W-1:0]        position,
	output logic signed [hpq_pkg::VAL_W-1:0] max_value
);
	import hpq_pkg::*;

	dp_op_t   op;
	dp_stat_t stat;

	// sequencer
	hpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.stat     (stat),
		.op       (op)
	);

	// heap storage and arithmetic
	hpq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.value     (value),
		.op        (op),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.position  (position),
		.max_value (max_value)
	);

endmodule

// ----- sim/testbench.sv -----
// testbench for max_heap_priority_queue: directed table, then random request traffic
// with random idling on both channels, checked against a heap predictor in this file
// depends on rtl/hpq_pkg.sv and rtl/max_heap_priority_queue.sv
`timescale 1ns / 1ps

module testbench;
	import hpq_pkg::*;

	localparam int HEAP_DEPTH  = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 600;
	localparam int CFG_SETTLE  = 8;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic             status;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] max_value;
	} heap_result_t;

	typedef struct packed {
		logic             is_cfg;
		logic             act;
		logic [VAL_W-1:0] val;
		logic             pinned;
		heap_result_t     want;
	} plan_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CAP_W-1:0]        cfg_wdata;
	logic                    in_valid;
	logic                    in_ready;
	logic                    action;
	logic signed [VAL_W-1:0] value;
	logic                    out_valid;
	logic                    out_ready;
	logic                    status;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] max_value;

	// result typed into the table, carried alongside the request
	logic         pin_valid;
	heap_result_t pin_want;

	// predictor state
	logic signed [VAL_W-1:0] heap_m [0:HEAP_DEPTH-1];
	int count_m;
	int cap_m;

	heap_result_t expected_q [$];
	plan_row_t    plan [$];
	int errors;
	int results_seen;
	int cycle_count;
	int tx_mode;
	int rx_mode;
	int hold_requests;
	int holds_done;

	max_heap_priority_queue #(.DEPTH(HEAP_DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.position  (position),
		.max_value (max_value)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// heap predictor: applies one request and returns its result
	function automatic heap_result_t heap_apply(input logic act, input logic [VAL_W-1:0] v);
		heap_result_t r;
		int bound, i, p, l, rr, m;
		bit stop;
		logic signed [VAL_W-1:0] t;
		r.status = ST_REJECT;
		r.position = '0;
		r.max_value = '0;
		bound = (cap_m < HEAP_DEPTH) ? cap_m : HEAP_DEPTH;
		if (act == ACT_INSERT) begin
			if (count_m < bound) begin
				// sift up while strictly greater than the parent
				i = count_m;
				heap_m[i] = v;
				stop = 1'b0;
				while (!stop && i != 0) begin
					p = (i - 1) / 2;
					if (heap_m[i] > heap_m[p]) begin
						t = heap_m[i];
						heap_m[i] = heap_m[p];
						heap_m[p] = t;
						i = p;
					end else begin
						stop = 1'b1;
					end
				end
				count_m++;
				r.status = ST_DONE;
				r.position = POS_W'(i + 1);
			end
		end else if (count_m != 0) begin
			r.status = ST_DONE;
			r.max_value = heap_m[0];
			count_m--;
			if (count_m != 0) begin
				// last entry to the root, then sift down toward the larger child
				heap_m[0] = heap_m[count_m];
				i = 0;
				stop = 1'b0;
				while (!stop) begin
					l = 2 * i + 1;
					rr = l + 1;
					if (l >= count_m) begin
						stop = 1'b1;
					end else begin
						m = l;
						if (rr < count_m && heap_m[rr] > heap_m[l])
							m = rr;
						if (heap_m[m] > heap_m[i]) begin
							t = heap_m[i];
							heap_m[i] = heap_m[m];
							heap_m[m] = t;
							i = m;
						end else begin
							stop = 1'b1;
						end
					end
				end
				r.position = POS_W'(i + 1);
			end
		end
		return r;
	endfunction

	function automatic int draw_wait(input int mode);
		case (mode)
			0:       return 0;
			1:       return $urandom_range(0, 18);
			default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
		endcase
	endfunction

	// extremes, near-equal small values and full random words
	function automatic logic [VAL_W-1:0] random_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 9))
			0:       v = 32'h7fff_ffff;
			1:       v = 32'h8000_0000;
			2, 3:    v = $urandom_range(0, 6) - 3;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	task automatic report(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		$display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
		errors++;
	endtask

	// checker and predictor, both on the rising edge
	always @(posedge clk) begin : monitor
		heap_result_t e;
		if (arst_n) begin
			if (cfg_we)
				cap_m = int'(cfg_wdata);
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					report("result with no request pending, max_value", max_value, '0);
				end else begin
					e = expected_q.pop_front();
					if (status !== e.status)
						report("status", status, e.status);
					if (position !== e.position)
						report("position", position, e.position);
					if (max_value !== e.max_value)
						report("max_value", max_value, e.max_value);
				end
			end
			if (in_valid && in_ready) begin
				e = heap_apply(action, value);
				if (pin_valid)
					e = pin_want;
				expected_q.push_back(e);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL max_heap_priority_queue");
			$finish;
		end
	end

	// result side: random stall per result, one long hold on request
	initial begin : receiver
		int w;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_requests != holds_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				holds_done++;
			end
			w = draw_wait(rx_mode);
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// offer one request and wait for it to be taken
	task automatic offer(input logic act, input logic [VAL_W-1:0] val, input logic pinned,
			input heap_result_t want);
		int g;
		g = draw_wait(tx_mode);
		@(negedge clk);
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		action    <= act;
		value     <= val;
		pin_valid <= pinned;
		pin_want  <= want;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// capacity write once every result is back
	task automatic set_capacity(input logic [CAP_W-1:0] c);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic plan_req(input logic act, input logic [VAL_W-1:0] val);
		plan.push_back('{1'b0, act, val, 1'b0, heap_result_t'('0)});
	endtask

	task automatic plan_pin(input logic act, input logic [VAL_W-1:0] val, input logic st,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] maxv);
		plan.push_back('{1'b0, act, val, 1'b1, heap_result_t'({st, pos, maxv})});
	endtask

	task automatic plan_cfg(input logic [CAP_W-1:0] c);
		plan.push_back('{1'b1, ACT_INSERT, VAL_W'(c), 1'b0, heap_result_t'('0)});
	endtask

	// random traffic at one capacity setting
	task automatic run_phase(input int cap, input int n, input int insert_pct, input int hold_at);
		int k;
		logic a;
		set_capacity(cap[CAP_W-1:0]);
		for (k = 0; k < n; k++) begin
			if (k % 64 == 0) begin
				tx_mode = $urandom_range(0, 2);
				rx_mode = $urandom_range(0, 2);
			end
			if (k == hold_at) begin
				tx_mode = 0;
				hold_requests++;
			end
			a = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_EXTRACT;
			offer(a, random_value(), 1'b0, heap_result_t'('0));
		end
	endtask

	initial begin : stimulus
		plan_row_t row;
		int k;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		action    = ACT_INSERT;
		value     = '0;
		pin_valid = 1'b0;
		pin_want  = '0;
		tx_mode   = 1;
		rx_mode   = 1;
		count_m   = 0;
		cap_m     = int'(CAP_RESET);
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed table
		plan_pin(ACT_EXTRACT, 32'h1234_5678, ST_REJECT, 11'd0, 32'd0);   // empty after reset
		plan_pin(ACT_INSERT,  32'h7fff_ffff, ST_DONE,   11'd1, 32'd0);
		plan_pin(ACT_INSERT,  32'h8000_0000, ST_DONE,   11'd2, 32'd0);
		plan_req(ACT_INSERT,  32'h7fff_ffff);                            // equal to root, stays
		plan_req(ACT_INSERT,  32'hffff_ffff);
		plan_req(ACT_EXTRACT, 32'h0);
		plan_req(ACT_EXTRACT, 32'hffff_ffff);
		plan_req(ACT_EXTRACT, 32'h0);
		plan_req(ACT_EXTRACT, 32'h0);                                    // heap empties
		plan_pin(ACT_EXTRACT, 32'h0,         ST_REJECT, 11'd0, 32'd0);
		plan_cfg(11'd0);                                                 // capacity zero
		plan_pin(ACT_INSERT,  32'd5,         ST_REJECT, 11'd0, 32'd0);
		plan_pin(ACT_EXTRACT, 32'd5,         ST_REJECT, 11'd0, 32'd0);
		plan_cfg(11'd2);
		plan_pin(ACT_INSERT,  32'd10,        ST_DONE,   11'd1, 32'd0);
		plan_pin(ACT_INSERT,  32'd20,        ST_DONE,   11'd1, 32'd0);
		plan_pin(ACT_INSERT,  32'd30,        ST_REJECT, 11'd0, 32'd0);   // full
		plan_cfg(11'd1);                                                 // below the count
		plan_req(ACT_EXTRACT, 32'd0);
		plan_pin(ACT_INSERT,  32'd7,         ST_REJECT, 11'd0, 32'd0);
		plan_pin(ACT_EXTRACT, 32'd0,         ST_DONE,   11'd0, 32'd10);  // last entry out
		plan_cfg(11'd2047);                                              // saturates at depth
		plan_pin(ACT_INSERT,  32'd0,         ST_DONE,   11'd1, 32'd0);
		plan_pin(ACT_EXTRACT, 32'hffff_ffff, ST_DONE,   11'd0, 32'd0);

		for (k = 0; k < plan.size(); k++) begin
			row = plan[k];
			if (row.is_cfg)
				set_capacity(row.val[CAP_W-1:0]);
			else
				offer(row.act, row.val, row.pinned, row.want);
		end

		// random part: small bounds, then fill to depth with a long output hold, then a few
		// requests with the capacity below the count
		run_phase(1, 10, 60, -1);
		run_phase(6, 10, 55, -1);
		run_phase($urandom_range(2, 40), 10, 55, -1);
		run_phase(2047, 1030, 100, 300);
		run_phase(1020, 10, 35, -1);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("PASS max_heap_priority_queue");
		else
			$display("FAIL max_heap_priority_queue");
		$finish;
	end

endmodule
